// ===== sv/rmq_pkg.sv =====
// Shared types, constants and helpers for the matrix-to-quaternion pipeline.
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int ELEM_W  = 16;
    localparam int ARG_W   = 19;
    localparam int RAD_W   = 35;   // root argument shifted left by 16
    localparam int ROOT_W  = 18;   // floor(sqrt(RAD)) fits in 18 bits
    localparam int NUM_W   = 17;   // off-diagonal sum or difference
    localparam int MAG_W   = 16;   // magnitude of a numerator
    localparam int DIVD_W  = 31;   // magnitude shifted left by 14
    localparam int QUO_W   = 31;
    localparam int ONE_Q14 = 16384;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_M0    = 2'd1,
        BR_M5    = 2'd2,
        BR_M10   = 2'd3
    } branch_t;

    // Per-item control that travels alongside the datapath
    typedef struct packed {
        logic    valid;
        branch_t branch;
        logic    invalid;
    } ctl_t;

    // Saturate an unsigned quotient and apply sign to a Q2.14 value
    function automatic logic signed [15:0] sat_signed(
        input logic [QUO_W-1:0] mag,
        input logic             neg
    );
        logic signed [15:0] r;
        begin
            if (neg) begin
                if (mag >= QUO_W'(32768)) r = 16'sh8000;
                else r = -$signed({1'b0, mag[14:0]});
            end else begin
                if (mag >= QUO_W'(32767)) r = 16'sh7fff;
                else r = $signed({1'b0, mag[14:0]});
            end
            return r;
        end
    endfunction

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//  channel   ports                                   handshake
//  input     elem_0..elem_10 (nine, Q2.14)           start (busy is always low)
//  result    quat_w/x/y/z, branch_taken, invalid     done strobe, one cycle
//
// One item may enter every cycle; latency is set by the front-end register,
// the 18-stage root recurrence, the divider (31 quotient stages and a sign
// stage) and the output register.
// Reset clears only valid bits and control structs; payload registers carry no reset.
// The receiver cannot stall, so nothing is held back and busy stays low.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] elem_0,
    input  logic signed [15:0] elem_1,
    input  logic signed [15:0] elem_2,
    input  logic signed [15:0] elem_4,
    input  logic signed [15:0] elem_5,
    input  logic signed [15:0] elem_6,
    input  logic signed [15:0] elem_8,
    input  logic signed [15:0] elem_9,
    input  logic signed [15:0] elem_10,
    output logic               done,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic [1:0]         branch_taken,
    output logic               invalid
);

    localparam int DLAT = rmq_pkg::QUO_W + 1;

    rmq_pkg::ctl_t                    f_ctl, s_ctl;
    logic [rmq_pkg::RAD_W-1:0]        f_rad;
    logic signed [rmq_pkg::NUM_W-1:0] f_na, f_nb, f_nc, s_na, s_nb, s_nc;
    logic [rmq_pkg::ROOT_W-1:0]       s_root, dsr;
    logic                             va, vb, vc;
    logic signed [15:0]               qa, qb, qc;

    rmq_pkg::ctl_t                    dctl_reg  [DLAT];
    logic signed [15:0]               main_reg  [DLAT];
    logic                             out_v_reg;
    logic signed [15:0]               w_reg, x_reg, y_reg, z_reg;
    logic [1:0]                       br_reg;
    logic                             inv_reg;
    logic [rmq_pkg::ROOT_W-1:0]       main_full;

    assign busy = 1'b0;

    rmq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2),
        .elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6),
        .elem_8(elem_8), .elem_9(elem_9), .elem_10(elem_10),
        .ctl(f_ctl), .radicand(f_rad),
        .num_a(f_na), .num_b(f_nb), .num_c(f_nc)
    );

    rmq_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .ctl_in(f_ctl), .radicand(f_rad),
        .num_a_in(f_na), .num_b_in(f_nb), .num_c_in(f_nc),
        .ctl_out(s_ctl), .root(s_root),
        .num_a_out(s_na), .num_b_out(s_nb), .num_c_out(s_nc)
    );

    // Invalid items divide by one; their results are forced to zero later
    assign dsr = (s_root == '0) ? rmq_pkg::ROOT_W'(1) : s_root;

    rmq_div u_div_a (.clk(clk), .rst_n(rst_n), .in_valid(s_ctl.valid),
                     .num(s_na), .divisor(dsr), .out_valid(va), .quot(qa));
    rmq_div u_div_b (.clk(clk), .rst_n(rst_n), .in_valid(s_ctl.valid),
                     .num(s_nb), .divisor(dsr), .out_valid(vb), .quot(qb));
    rmq_div u_div_c (.clk(clk), .rst_n(rst_n), .in_valid(s_ctl.valid),
                     .num(s_nc), .divisor(dsr), .out_valid(vc), .quot(qc));

    // Main component S/4 rounded half up; never saturates
    assign main_full = (s_root + rmq_pkg::ROOT_W'(2)) >> 2;

    // Control and main component delay line matching the dividers
    genvar g;
    generate
        for (g = 0; g < DLAT; g++) begin : g_dly
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    dctl_reg[g] <= '0;
                end else begin
                    dctl_reg[g] <= (g == 0) ? s_ctl : dctl_reg[(g == 0) ? 0 : g-1];
                end
            end
            always_ff @(posedge clk)
            begin
                main_reg[g] <= (g == 0) ? $signed(main_full[15:0])
                                        : main_reg[(g == 0) ? 0 : g-1];
            end
        end
    endgenerate

    // Output register: place components by branch, or zero them for invalid items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= dctl_reg[DLAT-1].valid & va & vb & vc;
        end
    end

    always_ff @(posedge clk)
    begin
        br_reg  <= dctl_reg[DLAT-1].branch;
        inv_reg <= dctl_reg[DLAT-1].invalid;
        if (dctl_reg[DLAT-1].invalid) begin
            w_reg <= '0; x_reg <= '0; y_reg <= '0; z_reg <= '0;
        end else begin
            unique case (dctl_reg[DLAT-1].branch)
                rmq_pkg::BR_TRACE: begin
                    w_reg <= main_reg[DLAT-1]; x_reg <= qa; y_reg <= qb; z_reg <= qc;
                end
                rmq_pkg::BR_M0: begin
                    w_reg <= qa; x_reg <= main_reg[DLAT-1]; y_reg <= qb; z_reg <= qc;
                end
                rmq_pkg::BR_M5: begin
                    w_reg <= qa; x_reg <= qb; y_reg <= main_reg[DLAT-1]; z_reg <= qc;
                end
                default: begin
                    w_reg <= qa; x_reg <= qb; y_reg <= qc; z_reg <= main_reg[DLAT-1];
                end
            endcase
        end
    end

    assign done         = out_v_reg;
    assign quat_w       = w_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign branch_taken = br_reg;
    assign invalid      = inv_reg;

endmodule

// ===== sv/rmq_front.sv =====
// Front end: branch choice, root argument and the three numerators.
`timescale 1ns / 1ps

module rmq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_0,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_1,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_2,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_4,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_5,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_6,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_8,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_9,
    input  logic signed [rmq_pkg::ELEM_W-1:0]   elem_10,
    output rmq_pkg::ctl_t                       ctl,
    output logic [rmq_pkg::RAD_W-1:0]           radicand,
    output logic signed [rmq_pkg::NUM_W-1:0]    num_a,
    output logic signed [rmq_pkg::NUM_W-1:0]    num_b,
    output logic signed [rmq_pkg::NUM_W-1:0]    num_c
);

    logic signed [rmq_pkg::ARG_W-1:0] m0, m5, m10, trace, arg;
    logic signed [rmq_pkg::NUM_W-1:0] d96, d28, d41, s14, s28, s69;
    rmq_pkg::branch_t                 br;
    logic signed [rmq_pkg::NUM_W-1:0] na, nb, nc;
    rmq_pkg::ctl_t                    ctl_reg;
    logic [rmq_pkg::RAD_W-1:0]        rad_reg;
    logic signed [rmq_pkg::NUM_W-1:0] na_reg, nb_reg, nc_reg;

    // Branch selection with strict compares
    always_comb
    begin
        m0    = rmq_pkg::ARG_W'(elem_0);
        m5    = rmq_pkg::ARG_W'(elem_5);
        m10   = rmq_pkg::ARG_W'(elem_10);
        trace = m0 + m5 + m10;
        d96 = rmq_pkg::NUM_W'(elem_9) - rmq_pkg::NUM_W'(elem_6);
        d28 = rmq_pkg::NUM_W'(elem_2) - rmq_pkg::NUM_W'(elem_8);
        d41 = rmq_pkg::NUM_W'(elem_4) - rmq_pkg::NUM_W'(elem_1);
        s14 = rmq_pkg::NUM_W'(elem_1) + rmq_pkg::NUM_W'(elem_4);
        s28 = rmq_pkg::NUM_W'(elem_2) + rmq_pkg::NUM_W'(elem_8);
        s69 = rmq_pkg::NUM_W'(elem_6) + rmq_pkg::NUM_W'(elem_9);
        if (trace > 0) begin
            br = rmq_pkg::BR_TRACE;
            arg = trace + rmq_pkg::ARG_W'(rmq_pkg::ONE_Q14);
            na = d96; nb = d28; nc = d41;
        end else if (m0 > m5 && m0 > m10) begin
            br = rmq_pkg::BR_M0;
            arg = rmq_pkg::ARG_W'(rmq_pkg::ONE_Q14) + m0 - m5 - m10;
            na = d96; nb = s14; nc = s28;
        end else if (m5 > m10) begin
            br = rmq_pkg::BR_M5;
            arg = rmq_pkg::ARG_W'(rmq_pkg::ONE_Q14) + m5 - m0 - m10;
            na = d28; nb = s14; nc = s69;
        end else begin
            br = rmq_pkg::BR_M10;
            arg = rmq_pkg::ARG_W'(rmq_pkg::ONE_Q14) + m10 - m0 - m5;
            na = d41; nb = s28; nc = s69;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg.valid   <= in_valid;
            ctl_reg.branch  <= br;
            ctl_reg.invalid <= (arg <= 0);
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= (arg <= 0) ? '0
                              : rmq_pkg::RAD_W'({arg[rmq_pkg::ARG_W-2:0], 16'd0});
        na_reg  <= na;
        nb_reg  <= nb;
        nc_reg  <= nc;
    end

    assign ctl      = ctl_reg;
    assign radicand = rad_reg;
    assign num_a    = na_reg;
    assign num_b    = nb_reg;
    assign num_c    = nc_reg;

endmodule

// ===== sv/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage (18 stages).
`timescale 1ns / 1ps

module rmq_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rmq_pkg::ctl_t                    ctl_in,
    input  logic [rmq_pkg::RAD_W-1:0]        radicand,
    input  logic signed [rmq_pkg::NUM_W-1:0] num_a_in,
    input  logic signed [rmq_pkg::NUM_W-1:0] num_b_in,
    input  logic signed [rmq_pkg::NUM_W-1:0] num_c_in,
    output rmq_pkg::ctl_t                    ctl_out,
    output logic [rmq_pkg::ROOT_W-1:0]       root,
    output logic signed [rmq_pkg::NUM_W-1:0] num_a_out,
    output logic signed [rmq_pkg::NUM_W-1:0] num_b_out,
    output logic signed [rmq_pkg::NUM_W-1:0] num_c_out
);

    localparam int NS  = rmq_pkg::ROOT_W;
    localparam int RW  = 2 * NS;          // radicand width
    localparam int REMW = NS + 2;

    rmq_pkg::ctl_t                    ctl_reg  [NS];
    logic [RW-1:0]                    rad_reg  [NS];
    logic [REMW-1:0]                  rem_reg  [NS];
    logic [NS-1:0]                    q_reg    [NS];
    logic signed [rmq_pkg::NUM_W-1:0] na_reg   [NS];
    logic signed [rmq_pkg::NUM_W-1:0] nb_reg   [NS];
    logic signed [rmq_pkg::NUM_W-1:0] nc_reg   [NS];

    // Restoring digit recurrence: bring down two bits, try 4q+1
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [RW-1:0]   rad_p;
            logic [REMW-1:0] rem_p;
            logic [NS-1:0]   q_p;
            rmq_pkg::ctl_t   ctl_p;
            logic signed [rmq_pkg::NUM_W-1:0] na_p, nb_p, nc_p;
            logic [REMW+1:0] trial_rem, trial_sub;

            if (g == 0) begin : g_first
                assign rad_p = RW'(radicand);
                assign rem_p = '0;
                assign q_p   = '0;
                assign ctl_p = ctl_in;
                assign na_p  = num_a_in;
                assign nb_p  = num_b_in;
                assign nc_p  = num_c_in;
            end else begin : g_next
                assign rad_p = rad_reg[g-1];
                assign rem_p = rem_reg[g-1];
                assign q_p   = q_reg[g-1];
                assign ctl_p = ctl_reg[g-1];
                assign na_p  = na_reg[g-1];
                assign nb_p  = nb_reg[g-1];
                assign nc_p  = nc_reg[g-1];
            end

            assign trial_rem = {rem_p, rad_p[RW-1:RW-2]};
            assign trial_sub = {(REMW - NS)'(0), q_p, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    ctl_reg[g] <= '0;
                end else begin
                    ctl_reg[g] <= ctl_p;
                end
            end

            always_ff @(posedge clk)
            begin
                rad_reg[g] <= {rad_p[RW-3:0], 2'b00};
                na_reg[g]  <= na_p;
                nb_reg[g]  <= nb_p;
                nc_reg[g]  <= nc_p;
                if (trial_rem >= trial_sub) begin
                    rem_reg[g] <= REMW'(trial_rem - trial_sub);
                    q_reg[g]   <= {q_p[NS-2:0], 1'b1};
                end else begin
                    rem_reg[g] <= REMW'(trial_rem);
                    q_reg[g]   <= {q_p[NS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign ctl_out   = ctl_reg[NS-1];
    assign root      = q_reg[NS-1];
    assign num_a_out = na_reg[NS-1];
    assign num_b_out = nb_reg[NS-1];
    assign num_c_out = nc_reg[NS-1];

endmodule

// ===== sv/rmq_div.sv =====
// Pipelined rounded divider: |num|*16384 + s/2 over s, one quotient bit per stage.
`timescale 1ns / 1ps

module rmq_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [rmq_pkg::NUM_W-1:0] num,
    input  logic [rmq_pkg::ROOT_W-1:0]       divisor,
    output logic                             out_valid,
    output logic signed [15:0]               quot
);

    localparam int NS = rmq_pkg::QUO_W;
    localparam int DW = rmq_pkg::DIVD_W + 2;   // dividend incl. rounding term
    localparam int RW = rmq_pkg::ROOT_W + 1;

    logic           v_reg   [NS];
    logic           neg_reg [NS];
    logic [DW-1:0]  dvd_reg [NS];
    logic [RW-1:0]  rem_reg [NS];
    logic [NS-1:0]  q_reg   [NS];
    logic [rmq_pkg::ROOT_W-1:0] dsr_reg [NS];
    logic signed [15:0] out_reg;
    logic               out_v_reg;

    logic [rmq_pkg::MAG_W:0] mag0;
    logic [DW-1:0]           dvd0;

    // Dividend: magnitude shifted by 14 plus half the divisor
    always_comb
    begin
        mag0 = num[rmq_pkg::NUM_W-1] ? (rmq_pkg::MAG_W+1)'(-num)
                                     : (rmq_pkg::MAG_W+1)'(num);
        dvd0 = DW'({mag0, 14'd0}) + DW'(divisor >> 1);
    end

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic           v_p, neg_p;
            logic [DW-1:0]  dvd_p;
            logic [RW-1:0]  rem_p;
            logic [NS-1:0]  q_p;
            logic [rmq_pkg::ROOT_W-1:0] dsr_p;
            logic [RW:0]    trial;

            if (g == 0) begin : g_first
                assign v_p   = in_valid;
                assign neg_p = num[rmq_pkg::NUM_W-1];
                assign dvd_p = dvd0 << (DW - NS);
                assign rem_p = '0;
                assign q_p   = '0;
                assign dsr_p = divisor;
            end else begin : g_next
                assign v_p   = v_reg[g-1];
                assign neg_p = neg_reg[g-1];
                assign dvd_p = dvd_reg[g-1];
                assign rem_p = rem_reg[g-1];
                assign q_p   = q_reg[g-1];
                assign dsr_p = dsr_reg[g-1];
            end

            assign trial = {rem_p, dvd_p[DW-1]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    v_reg[g] <= 1'b0;
                end else begin
                    v_reg[g] <= v_p;
                end
            end

            always_ff @(posedge clk)
            begin
                neg_reg[g] <= neg_p;
                dvd_reg[g] <= {dvd_p[DW-2:0], 1'b0};
                dsr_reg[g] <= dsr_p;
                if (trial >= (RW+1)'(dsr_p)) begin
                    rem_reg[g] <= RW'(trial - (RW+1)'(dsr_p));
                    q_reg[g]   <= {q_p[NS-2:0], 1'b1};
                end else begin
                    rem_reg[g] <= RW'(trial);
                    q_reg[g]   <= {q_p[NS-2:0], 1'b0};
                end
            end
        end
    endgenerate

    // Sign and saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= rmq_pkg::sat_signed(q_reg[NS-1], neg_reg[NS-1]);
    end

    assign out_valid = out_v_reg;
    assign quot      = out_reg;

endmodule

// ===== tb/sv/tb_rotation_matrix_to_quaternion.sv =====
// Testbench for the rotation matrix to quaternion block: directed and random matrices.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

    localparam int LATENCY = 52;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        rmq_pkg::branch_t   br;
        logic               inv;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] elem_0 = '0, elem_1 = '0, elem_2 = '0, elem_4 = '0, elem_5 = '0;
    logic signed [15:0] elem_6 = '0, elem_8 = '0, elem_9 = '0, elem_10 = '0;
    logic done, invalid;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic [1:0] branch_taken;

    quat_t pending_quats[$];
    int    errors = 0;
    int    idle_pct = 0;

    rotation_matrix_to_quaternion dut (.*);

    always #2 clk = ~clk;

    // Bit-exact integer square root
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // num * 16384 / s, nearest, ties away from zero
    function automatic logic signed [15:0] scaled_div(longint num, longint unsigned s);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q = ((mag << 14) + (s >> 1)) / s;
        return clamp16((num < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t predict_quat(longint m0, longint m1, longint m2, longint m4,
                                           longint m5, longint m6, longint m8, longint m9,
                                           longint m10);
        quat_t q;
        longint tr, arg;
        longint unsigned s;
        logic signed [15:0] mc;
        q.w = '0; q.x = '0; q.y = '0; q.z = '0;
        q.br = rmq_pkg::BR_TRACE;
        q.inv = 1'b0;
        tr = m0 + m5 + m10;
        if (tr > 0) begin
            q.br = rmq_pkg::BR_TRACE; arg = tr + rmq_pkg::ONE_Q14;
        end else if (m0 > m5 && m0 > m10) begin
            q.br = rmq_pkg::BR_M0; arg = rmq_pkg::ONE_Q14 + m0 - m5 - m10;
        end else if (m5 > m10) begin
            q.br = rmq_pkg::BR_M5; arg = rmq_pkg::ONE_Q14 + m5 - m0 - m10;
        end else begin
            q.br = rmq_pkg::BR_M10; arg = rmq_pkg::ONE_Q14 + m10 - m0 - m5;
        end
        q.inv = (arg <= 0);
        if (!q.inv) begin
            s = int_sqrt(longint'(arg) << 16);
            mc = clamp16((s + 2) >> 2);
            case (q.br)
                rmq_pkg::BR_TRACE: begin
                    q.w = mc; q.x = scaled_div(m9 - m6, s);
                    q.y = scaled_div(m2 - m8, s); q.z = scaled_div(m4 - m1, s);
                end
                rmq_pkg::BR_M0: begin
                    q.w = scaled_div(m9 - m6, s); q.x = mc;
                    q.y = scaled_div(m1 + m4, s); q.z = scaled_div(m2 + m8, s);
                end
                rmq_pkg::BR_M5: begin
                    q.w = scaled_div(m2 - m8, s); q.x = scaled_div(m1 + m4, s);
                    q.y = mc; q.z = scaled_div(m6 + m9, s);
                end
                default: begin
                    q.w = scaled_div(m4 - m1, s); q.x = scaled_div(m2 + m8, s);
                    q.y = scaled_div(m6 + m9, s); q.z = mc;
                end
            endcase
        end
        return q;
    endfunction

    // Send one matrix, with random idle cycles before it
    task automatic send_matrix(input logic signed [15:0] e [9]);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        elem_0 <= e[0]; elem_1 <= e[1]; elem_2 <= e[2];
        elem_4 <= e[3]; elem_5 <= e[4]; elem_6 <= e[5];
        elem_8 <= e[6]; elem_9 <= e[7]; elem_10 <= e[8];
        do @(posedge clk); while (busy);
        pending_quats.push_back(predict_quat(e[0], e[1], e[2], e[3], e[4], e[5],
                                             e[6], e[7], e[8]));
    endtask

    task automatic drain_quats();
        start <= 1'b0;
        @(posedge clk);
        while (pending_quats.size() != 0) @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk) begin
        quat_t exp_q;
        if (rst_n && done) begin
            if (pending_quats.size() == 0) begin
                $display("%0t: unexpected item: w=%0d x=%0d y=%0d z=%0d", $time,
                         quat_w, quat_x, quat_y, quat_z);
                errors++;
            end else begin
                exp_q = pending_quats.pop_front();
                if (quat_w !== exp_q.w || quat_x !== exp_q.x || quat_y !== exp_q.y ||
                    quat_z !== exp_q.z || branch_taken !== exp_q.br ||
                    invalid !== exp_q.inv) begin
                    $display("%0t: mismatch exp w=%0d x=%0d y=%0d z=%0d br=%0d inv=%0d",
                             $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.br, exp_q.inv);
                    $display("%0t:          got w=%0d x=%0d y=%0d z=%0d br=%0d inv=%0d",
                             $time, quat_w, quat_x, quat_y, quat_z, branch_taken, invalid);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(5, 0))
            0: return 16'($urandom());
            1: return 16'sh4000;
            2: return -16'sh4000;
            default: return 16'(int'($urandom_range(32768, 0)) - 16384);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] e [9];
        idle_pct = 0;
        e = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000}; send_matrix(e);
        // each diagonal dominant, rest negative
        e = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000}; send_matrix(e);
        e = '{-16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, -16'sh4000}; send_matrix(e);
        e = '{-16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 16'sh4000}; send_matrix(e);
        // full tie at zero trace falls to last branch
        e = '{0, 100, -200, 300, 0, -400, 500, -600, 0}; send_matrix(e);
        // tie of the first two diagonals
        e = '{-100, 5, 6, 7, -100, 8, 9, 10, -200}; send_matrix(e);
        // negative diagonals, root argument still positive
        e = '{-16'sh4000, 1, 2, 3, -16'sh4000, 4, 5, 6, -16'sh4000}; send_matrix(e);
        e = '{16'sh8000, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}; send_matrix(e);
        // full-range patterns
        e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh8000}; send_matrix(e);
        e = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh8000, 16'sh8000}; send_matrix(e);
        e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff}; send_matrix(e);
        e = '{-16'sh0001, 16'sh7fff, 16'sh8000, 16'sh7fff, -16'sh0001, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh0000}; send_matrix(e);
        // trace just above zero
        e = '{1, -16384, 16384, 16384, 0, -16384, -16384, 16384, 0}; send_matrix(e);
        drain_quats();
    endtask

    task automatic test_random(input int pct, input int count);
        logic signed [15:0] e [9];
        idle_pct = pct;
        repeat (count) begin
            foreach (e[i]) e[i] = rand_elem();
            send_matrix(e);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 130);
        test_random(68, 130);
        // sender waits for every result before continuing
        drain_quats();
        test_random(13, 130);
        drain_quats();
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
